/* rtl/core/cbn_pkg.sv */
package cbn_pkg;

   localparam int COORD_W = 15;
   localparam int SIZE_W  = 14;
   localparam int CLASS_W = 3;
   localparam int AREA_W  = 2 * SIZE_W;
   localparam int UNION_W = AREA_W + 1;
   localparam int THR_W   = 8;
   localparam int PROD_W  = UNION_W + THR_W;
   localparam int SLOT_W  = 6;

   localparam logic [THR_W-1:0] THRESH_RESET = 8'd115;

   typedef struct packed {
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] top;
      logic [SIZE_W-1:0]         wid;
      logic [SIZE_W-1:0]         hgt;
      logic [CLASS_W-1:0]        cls;
   } box_type;

   typedef struct packed {
      box_type           box;
      logic [AREA_W-1:0] area;
   } entry_type;

   typedef struct packed {
      logic valid;
      logic hit;
   } cmp_result_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_AREA,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

/* rtl/core/classwise_box_nms.sv */
// Channel  Direction  Ports                               Moves
// req      in         req_valid / req_ready, req_*        one box item
// rsp      out        rsp_valid / rsp_ready, rsp_*        one verdict item per box
// csr      in         csr_wr_en, csr_wr_data              overlap threshold write
//
// After a box is accepted its area is registered; when the store is empty or full the
// scan is skipped, otherwise the result is registered only once every kept box has
// been compared (sooner when suppressed early). While scanning, one stored box enters the
// shared overlap pipeline per cycle through the single read port of the store.
// Reset empties the store and loads threshold 115.
// The block takes no new item until the current one has its result registered;
// a result waiting on rsp_ready holds only the finish of the next item.
module classwise_box_nms #(
   parameter int MAX_KEPT = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [14:0]          req_box_left,
   input  logic signed [14:0]          req_box_top,
   input  logic [13:0]                 req_box_width,
   input  logic [13:0]                 req_box_height,
   input  logic [2:0]                  req_class_label,
   input  logic                        req_frame_end,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_kept,
   output logic [5:0]                  rsp_kept_slot,
   output logic                        rsp_store_full,
   output logic                        rsp_frame_done,
   input  logic                        csr_wr_en,
   input  logic [7:0]                  csr_wr_data
);
   import cbn_pkg::*;

   localparam int CNT_W = $clog2(MAX_KEPT + 1);
   localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_KEPT);

   state_type         state_ff, state_in;
   box_type           cur_ff, cur_in;
   logic              fend_ff, fend_in;
   logic [AREA_W-1:0] area_ff, area_in;
   logic [CNT_W-1:0]  issue_ff, issue_in, done_ff, done_in, count_ff, count_in;
   logic              keep_ff, keep_in, full_ff, full_in;
   logic [THR_W-1:0]  thr_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kept_ff, rsp_kept_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic              rsp_full_ff, rsp_full_in;
   logic              rsp_fdone_ff, rsp_fdone_in;

   logic               rd_issue, flush, wr_en;
   logic [CNT_W+5:0]   slot_wide;
   entry_type          wr_entry, rd_entry;
   cmp_result_type     cmp;

   cbn_store #(
      .DEPTH  (MAX_KEPT),
      .ADDR_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_entry),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (rd_entry)
   );

   cbn_overlap u_overlap (
      .clock      (clock),
      .reset      (reset),
      .flush      (flush),
      .issue      (rd_issue),
      .kept_entry (rd_entry),
      .cur_box    (cur_ff),
      .cur_area   (area_ff),
      .threshold  (thr_ff),
      .result     (cmp)
   );

   assign wr_entry.box  = cur_ff;
   assign wr_entry.area = area_ff;
   assign slot_wide     = {6'b000000, count_ff};

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      fend_in      = fend_ff;
      area_in      = area_ff;
      issue_in     = issue_ff;
      done_in      = done_ff;
      count_in     = count_ff;
      keep_in      = keep_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kept_in  = rsp_kept_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_fdone_in = rsp_fdone_ff;
      req_ready    = 1'b0;
      rd_issue     = 1'b0;
      flush        = 1'b0;
      wr_en        = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cur_in.left = req_box_left;
               cur_in.top  = req_box_top;
               cur_in.wid  = req_box_width;
               cur_in.hgt  = req_box_height;
               cur_in.cls  = req_class_label;
               fend_in     = req_frame_end;
               state_in    = ST_AREA;
            end
         end
         ST_AREA: begin
            area_in  = {{SIZE_W{1'b0}}, cur_ff.wid} * {{SIZE_W{1'b0}}, cur_ff.hgt};
            issue_in = '0;
            done_in  = '0;
            full_in  = 1'b0;
            keep_in  = 1'b1;
            if (count_ff == MAX_CNT) begin
               full_in  = 1'b1;
               keep_in  = 1'b0;
               state_in = ST_FINISH;
            end else if (count_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cmp.valid && cmp.hit) begin
               // Suppressed: drop whatever is still in flight.
               keep_in  = 1'b0;
               flush    = 1'b1;
               state_in = ST_FINISH;
            end else begin
               if (issue_ff != count_ff) begin
                  rd_issue = 1'b1;
                  issue_in = issue_ff + 1'b1;
               end
               if (cmp.valid) begin
                  done_in = done_ff + 1'b1;
                  if (done_ff + 1'b1 == count_ff) begin
                     flush    = 1'b1;
                     state_in = ST_FINISH;
                  end
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_kept_in  = keep_ff;
               rsp_slot_in  = keep_ff ? slot_wide[SLOT_W-1:0] : '0;
               rsp_full_in  = full_ff;
               rsp_fdone_in = fend_ff;
               wr_en        = keep_ff;
               if (fend_ff) begin
                  count_in = '0;
               end else if (keep_ff) begin
                  count_in = count_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         thr_ff       <= THRESH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
      end
      cur_ff       <= cur_in;
      fend_ff      <= fend_in;
      area_ff      <= area_in;
      issue_ff     <= issue_in;
      done_ff      <= done_in;
      keep_ff      <= keep_in;
      full_ff      <= full_in;
      rsp_kept_ff  <= rsp_kept_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_fdone_ff <= rsp_fdone_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kept       = rsp_kept_ff;
   assign rsp_kept_slot  = rsp_slot_ff;
   assign rsp_store_full = rsp_full_ff;
   assign rsp_frame_done = rsp_fdone_ff;

endmodule

/* rtl/core/cbn_store.sv */
module cbn_store #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  cbn_pkg::entry_type wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output cbn_pkg::entry_type rd_data
);
   import cbn_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/cbn_overlap.sv */
module cbn_overlap (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       flush,
   input  logic                       issue,
   input  cbn_pkg::entry_type         kept_entry,
   input  cbn_pkg::box_type           cur_box,
   input  logic [cbn_pkg::AREA_W-1:0] cur_area,
   input  logic [cbn_pkg::THR_W-1:0]  threshold,
   output cbn_pkg::cmp_result_type    result
);
   import cbn_pkg::*;

   // Valid flags run alongside the data; the first one lines up with the
   // registered read data of the store.
   logic [4:0] valid_ff, valid_in;

   logic [SIZE_W-1:0]  iw_ff, iw_in, ih_ff, ih_in;
   logic [AREA_W-1:0]  karea1_ff, karea2_ff;
   logic [3:0]         match_ff;
   logic               match_in;
   logic [AREA_W-1:0]  inter2_ff, inter2_in, inter3_ff, inter4_ff;
   logic [UNION_W-1:0] uni3_ff, uni3_in;
   logic [PROD_W-1:0]  prod4_ff, prod4_in;

   logic signed [COORD_W+1:0] c_lo_x, c_hi_x, k_lo_x, k_hi_x;
   logic signed [COORD_W+1:0] c_lo_y, c_hi_y, k_lo_y, k_hi_y;
   logic signed [COORD_W+1:0] x1, x2, y1, y2;
   logic signed [COORD_W+2:0] dx, dy;

   always_comb begin
      valid_in = flush ? 5'b0 : {valid_ff[3:0], issue};

      c_lo_x = {{2{cur_box.left[COORD_W-1]}}, cur_box.left};
      k_lo_x = {{2{kept_entry.box.left[COORD_W-1]}}, kept_entry.box.left};
      c_lo_y = {{2{cur_box.top[COORD_W-1]}}, cur_box.top};
      k_lo_y = {{2{kept_entry.box.top[COORD_W-1]}}, kept_entry.box.top};
      c_hi_x = c_lo_x + $signed({3'b000, cur_box.wid});
      k_hi_x = k_lo_x + $signed({3'b000, kept_entry.box.wid});
      c_hi_y = c_lo_y + $signed({3'b000, cur_box.hgt});
      k_hi_y = k_lo_y + $signed({3'b000, kept_entry.box.hgt});

      x1 = (c_lo_x > k_lo_x) ? c_lo_x : k_lo_x;
      y1 = (c_lo_y > k_lo_y) ? c_lo_y : k_lo_y;
      x2 = (c_hi_x < k_hi_x) ? c_hi_x : k_hi_x;
      y2 = (c_hi_y < k_hi_y) ? c_hi_y : k_hi_y;
      dx = {x2[COORD_W+1], x2} - {x1[COORD_W+1], x1};
      dy = {y2[COORD_W+1], y2} - {y1[COORD_W+1], y1};

      // A positive overlap never exceeds the smaller size, so it fits SIZE_W.
      iw_in = (dx > 0) ? dx[SIZE_W-1:0] : '0;
      ih_in = (dy > 0) ? dy[SIZE_W-1:0] : '0;
      match_in = (kept_entry.box.cls == cur_box.cls);

      inter2_in = {{SIZE_W{1'b0}}, iw_ff} * {{SIZE_W{1'b0}}, ih_ff};
      uni3_in = {1'b0, cur_area} + {1'b0, karea2_ff} - {1'b0, inter2_ff};
      prod4_in = {{UNION_W{1'b0}}, threshold} * {{THR_W{1'b0}}, uni3_ff};

      result.valid = valid_ff[4];
      result.hit = match_ff[3] && ({1'b0, inter4_ff, 8'h00} > prod4_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      iw_ff     <= iw_in;
      ih_ff     <= ih_in;
      karea1_ff <= kept_entry.area;
      karea2_ff <= karea1_ff;
      match_ff  <= {match_ff[2:0], match_in};
      inter2_ff <= inter2_in;
      inter3_ff <= inter2_ff;
      inter4_ff <= inter3_ff;
      uni3_ff   <= uni3_in;
      prod4_ff  <= prod4_in;
   end

endmodule
